/* sv/aes256_cbc_decrypt_pkcs7_top_defines.svh */
// Assertion macros for the AES-256-CBC decrypt block.
// Used by aes256_cbc_decrypt_pkcs7_top.sv; needs a clk and rst in scope.
`ifndef AES256_CBC_DECRYPT_PKCS7_TOP_DEFINES_SVH
`define AES256_CBC_DECRYPT_PKCS7_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define CHK_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define CHK_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/acd_pkg.sv */
// Package for the AES-256-CBC decrypt block: sizes, register indexes,
// S-box tables built at elaboration and the round functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acd_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int KEY_BYTES   = 32;
  localparam int NUM_ROUNDS  = 14;
  localparam int NUM_KWORDS  = 60;

  // register indexes
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_IV_HIGH = 3'd4;
  localparam logic [2:0] REG_IV_LOW  = 3'd5;

  typedef logic [7:0] sbox_t [256];

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = 8'h00;
    aa  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ aa;
      aa = xtime(aa);
    end
    return acc;
  endfunction

  function automatic sbox_t gen_fwd_sbox();
    sbox_t tb;
    logic [7:0] b;
    logic [7:0] p;
    for (int x = 0; x < 256; x++) begin
      p = 8'(x);
      b = 8'h00;
      if (x != 0) begin
        b = 8'h01;
        for (int e = 0; e < 254; e++) b = gf_mul(b, p);
      end
      tb[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
              ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
    return tb;
  endfunction

  localparam sbox_t FWD_SBOX = gen_fwd_sbox();

  function automatic sbox_t gen_inv_sbox();
    sbox_t tb;
    for (int x = 0; x < 256; x++) tb[FWD_SBOX[x]] = 8'(x);
    return tb;
  endfunction

  localparam sbox_t INV_SBOX = gen_inv_sbox();

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // byte 0 sits in the top bits
  function automatic logic [127:0] inv_shift_sub(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = INV_SBOX[s[127-8*(4*((c+4-r)&3)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                         ^ gf_mul(a3, 8'd9);
      t[119-32*c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                         ^ gf_mul(a3, 8'd13);
      t[111-32*c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                         ^ gf_mul(a3, 8'd11);
      t[103-32*c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                         ^ gf_mul(a3, 8'd14);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* sv/aes256_cbc_decrypt_pkcs7_top.sv */
// AES-256-CBC decrypt with PKCS#7 check: key schedule, round key memory,
// round datapath and output register. Uses acd_pkg and the defines header.
//
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    cipher_high, cipher_low, final_block
// out      out  out_valid/out_stall  plain_high, plain_low, kept_bytes,
//                                    end_of_message, status
// cfg      in   APB psel/penable     paddr, pwdata, prdata (64-bit regs at 8*i)
//
// Each block, after its transfer, gets an initial key addition and
// fourteen inverse rounds, one per cycle, each reading its round key from the
// round key memory one round ahead. The next block is taken in the cycle after the last round.
// After reset and after each key register write, key expansion runs through
// 60 words, one per cycle, while in_stall is high.
// While a result waits under out_stall, the next block holds the last round.
`timescale 1ns / 1ps
`default_nettype none
`include "aes256_cbc_decrypt_pkcs7_top_defines.svh"

module aes256_cbc_decrypt_pkcs7_top import acd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] cipher_high,
  input  wire logic [63:0] cipher_low,
  input  wire logic        final_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      plain_high,
  output logic [63:0]      plain_low,
  output logic [4:0]       kept_bytes,
  output logic             end_of_message,
  output logic             status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {KSTART, EXPAND, IDLE, LOAD, ROUND} phase_t;

  phase_t       phase;
  logic [63:0]  cfg [6];
  logic [31:0]  win [8];
  logic [95:0]  wbuf;
  logic [5:0]   cnt;
  logic [7:0]   rc;
  logic [3:0]   rnd;
  logic [127:0] st;
  logic [127:0] cin;
  logic [127:0] xblk;
  logic [127:0] chain;
  logic         last;
  logic         message_start;

  logic [127:0] rk_mem [15];
  logic [127:0] rk_rd;
  logic [3:0]   raddr;

  logic         cfg_wr;
  logic [2:0]   cfg_idx;
  logic         key_wr;
  logic         in_xfer;
  logic         done;

  logic [31:0]  kt;
  logic [31:0]  kword;
  logic [127:0] plain;
  logic [7:0]   pad;
  logic         bad;
  logic [4:0]   kept;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];
  assign key_wr  = cfg_wr && cfg_idx <= REG_KEY3;
  assign in_stall = (phase != IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // last round finishes into the output register
  assign done = !key_wr && phase == ROUND && rnd == 4'd0 && (!out_valid || !out_stall);

  // register readback
  always_comb begin
    prdata = 64'd0;
    if (cfg_idx <= REG_IV_LOW) prdata = cfg[cfg_idx];
  end

  // next expanded key word
  always_comb begin
    kt = win[7];
    if (cnt[2:0] == 3'd0) kt = sub_word({win[7][23:0], win[7][31:24]}) ^ {rc, 24'd0};
    else if (cnt[2:0] == 3'd4) kt = sub_word(win[7]);
    kword = (cnt < 6'(KEY_BYTES / 4)) ? win[0] : (win[0] ^ kt);
  end

  // round key read address, one round ahead; key 0 held while the result waits
  always_comb begin
    case (phase)
      IDLE:    raddr = 4'(NUM_ROUNDS);
      LOAD:    raddr = 4'(NUM_ROUNDS - 1);
      ROUND:   raddr = (rnd == 4'd0) ? 4'd0 : rnd - 4'd1;
      default: raddr = 4'd0;
    endcase
  end

  // last round, CBC chaining and padding check
  always_comb begin
    plain = inv_shift_sub(st) ^ rk_rd ^ xblk;
    pad   = plain[7:0];
    bad   = 1'b0;
    if (pad == 8'd0 || pad > 8'(BLOCK_BYTES)) bad = 1'b1;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      if (9'(k) >= 9'(BLOCK_BYTES) - {1'b0, pad} && plain[127-8*k -: 8] != pad) bad = 1'b1;
    end
    if (!last) bad = 1'b0;
    kept = 5'(BLOCK_BYTES);
    if (last) kept = bad ? 5'd0 : 5'(BLOCK_BYTES) - pad[4:0];
  end

  // round key memory
  always_ff @(posedge clk) begin
    if (phase == EXPAND && cnt[1:0] == 2'd3) rk_mem[cnt[5:2]] <= {wbuf, kword};
    rk_rd <= rk_mem[raddr];
  end

  // control, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= KSTART;
      message_start <= 1'b1;
      out_valid     <= 1'b0;
      cnt           <= 6'd0;
      rnd           <= 4'd0;
      for (int i = 0; i < 6; i++) cfg[i] <= 64'd0;
    end else begin
      if (done) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      // register writes; a key write reruns the schedule
      if (cfg_wr && cfg_idx <= REG_IV_LOW) cfg[cfg_idx] <= pwdata;
      if (key_wr) begin
        phase <= KSTART;
      end else begin
        case (phase)
          KSTART: begin
            for (int i = 0; i < 8; i++) win[i] <= cfg[i/2][63-32*(i%2) -: 32];
            cnt   <= 6'd0;
            rc    <= 8'h01;
            phase <= EXPAND;
          end
          EXPAND: begin
            for (int i = 0; i < 7; i++) win[i] <= win[i+1];
            win[7] <= kword;
            wbuf   <= {wbuf[63:0], kword};
            if (cnt >= 6'(KEY_BYTES / 4) && cnt[2:0] == 3'd0) rc <= xtime(rc);
            cnt <= cnt + 6'd1;
            if (cnt == 6'(NUM_KWORDS - 1)) phase <= IDLE;
          end
          IDLE: begin
            if (in_xfer) begin
              cin           <= {cipher_high, cipher_low};
              last          <= final_block;
              xblk          <= message_start ? {cfg[REG_IV_HIGH], cfg[REG_IV_LOW]} : chain;
              chain         <= {cipher_high, cipher_low};
              message_start <= final_block;
              phase         <= LOAD;
            end
          end
          LOAD: begin
            st    <= cin ^ rk_rd;
            rnd   <= 4'(NUM_ROUNDS - 1);
            phase <= ROUND;
          end
          ROUND: begin
            if (rnd != 4'd0) begin
              st  <= inv_mix(inv_shift_sub(st) ^ rk_rd);
              rnd <= rnd - 4'd1;
            end else if (done) begin
              plain_high     <= plain[127:64];
              plain_low      <= plain[63:0];
              kept_bytes     <= kept;
              end_of_message <= last;
              status         <= bad;
              phase          <= IDLE;
            end
          end
          default: phase <= KSTART;
        endcase
      end
    end
  end

  `CHK_NEXT(a_xfer_loads, in_xfer, phase == LOAD)
  `CHK_NEXT(a_key_restart, key_wr, phase == KSTART)
  `CHK_NOW(a_round_range, phase == ROUND, rnd < 4'(NUM_ROUNDS))

endmodule

`default_nettype wire

/* sim/acd_checker.sv */
// Scoreboard for the AES-256-CBC decrypt block: watches the input, output and
// register channels, predicts each plaintext block and compares. Needs acd_pkg.
`timescale 1ns / 1ps

module acd_checker import acd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [63:0] cipher_high,
  input  wire logic [63:0] cipher_low,
  input  wire logic        final_block,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [63:0] plain_high,
  input  wire logic [63:0] plain_low,
  input  wire logic [4:0]  kept_bytes,
  input  wire logic        end_of_message,
  input  wire logic        status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output int               fail_count,
  output int               pending
);

  localparam int NUM_REGS = 6;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  kept;
    logic        eom;
    logic        bad;
  } plain_block_t;

  logic [7:0]   sbox [256];
  logic [7:0]   isbox [256];
  logic [63:0]  regs [NUM_REGS];
  logic [63:0]  rkeys [30];
  logic [127:0] prev_cipher;
  bit           use_iv;
  plain_block_t plain_q [$];

  function automatic logic [7:0] dbl8(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] mul8(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl8(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rot8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [31:0] subw(logic [31:0] w);
    return {sbox[w[31:24]], sbox[w[23:16]], sbox[w[15:8]], sbox[w[7:0]]};
  endfunction

  // 60-word AES-256 schedule from the four key registers
  function automatic void expand_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = (i & 1) ? regs[i >> 1][31:0] : regs[i >> 1][63:32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if ((i & 7) == 0) begin
        t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl8(rc);
      end else if ((i & 7) == 4) begin
        t = subw(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int i = 0; i < 30; i++) rkeys[i] = {w[2*i], w[2*i+1]};
  endfunction

  // raw AES-256 inverse cipher under the current schedule; also used by the
  // stimulus to build ciphertext that decrypts to chosen padding
  function automatic logic [127:0] inv_cipher(logic [127:0] c);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] key;
    logic [127:0] res;
    logic [7:0]   a0, a1, a2, a3;
    for (int k = 0; k < 16; k++) s[k] = c[127-8*k -: 8];
    for (int r = 14; r >= 0; r--) begin
      if (r != 14) begin
        for (int cc = 0; cc < 4; cc++)
          for (int rr = 0; rr < 4; rr++)
            t[4*cc+rr] = isbox[s[4*((cc+4-rr)&3)+rr]];
        s = t;
      end
      key = {rkeys[2*r], rkeys[2*r+1]};
      for (int k = 0; k < 16; k++) s[k] ^= key[127-8*k -: 8];
      if (r != 14 && r != 0) begin
        for (int cc = 0; cc < 4; cc++) begin
          a0 = s[4*cc]; a1 = s[4*cc+1]; a2 = s[4*cc+2]; a3 = s[4*cc+3];
          s[4*cc]   = mul8(a0, 8'd14) ^ mul8(a1, 8'd11) ^ mul8(a2, 8'd13) ^ mul8(a3, 8'd9);
          s[4*cc+1] = mul8(a0, 8'd9) ^ mul8(a1, 8'd14) ^ mul8(a2, 8'd11) ^ mul8(a3, 8'd13);
          s[4*cc+2] = mul8(a0, 8'd13) ^ mul8(a1, 8'd9) ^ mul8(a2, 8'd14) ^ mul8(a3, 8'd11);
          s[4*cc+3] = mul8(a0, 8'd11) ^ mul8(a1, 8'd13) ^ mul8(a2, 8'd9) ^ mul8(a3, 8'd14);
        end
      end
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = s[k];
    return res;
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < NUM_REGS; i++) regs[i] = 64'h0;
    prev_cipher = 128'h0;
    use_iv = 1'b1;
    expand_keys();
  endfunction

  // S-boxes by inversion in GF(2^8) and the affine map
  initial begin
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = 8'h00;
      if (x != 0) begin
        b = 8'h01;
        for (int e = 0; e < 254; e++) b = mul8(b, 8'(x));
      end
      b = b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
      sbox[x] = b;
      isbox[b] = 8'(x);
    end
    clear_state();
  end

  always @(posedge clk) begin
    logic [127:0] cblk;
    logic [127:0] pblk;
    logic [7:0]   pad;
    logic         bad;
    plain_block_t exp_blk;
    if (rst) begin
      clear_state();
      plain_q.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready && paddr[5:3] < NUM_REGS) begin
        regs[paddr[5:3]] = pwdata;
        if (paddr[5:3] <= REG_KEY3) expand_keys();
      end
      // input transfer: predict
      if (in_valid && !in_stall) begin
        cblk = {cipher_high, cipher_low};
        pblk = inv_cipher(cblk) ^ (use_iv ? {regs[REG_IV_HIGH], regs[REG_IV_LOW]} : prev_cipher);
        bad = 1'b0;
        exp_blk.kept = 5'd16;
        if (final_block) begin
          pad = pblk[7:0];
          if (pad < 1 || pad > 16) bad = 1'b1;
          else
            for (int k = 16 - pad; k < 16; k++)
              if (pblk[127-8*k -: 8] != pad) bad = 1'b1;
          exp_blk.kept = bad ? 5'd0 : 5'(16 - pad);
        end
        exp_blk.hi = pblk[127:64];
        exp_blk.lo = pblk[63:0];
        exp_blk.eom = final_block;
        exp_blk.bad = bad;
        plain_q.push_back(exp_blk);
        prev_cipher = cblk;
        use_iv = final_block;
      end
      // output transfer: compare
      if (out_valid && !out_stall) begin
        if (plain_q.size() == 0) begin
          $error("unexpected output transfer");
          fail_count++;
        end else begin
          exp_blk = plain_q.pop_front();
          if (plain_high !== exp_blk.hi) begin
            $error("plain_high expected %h got %h", exp_blk.hi, plain_high);
            fail_count++;
          end
          if (plain_low !== exp_blk.lo) begin
            $error("plain_low expected %h got %h", exp_blk.lo, plain_low);
            fail_count++;
          end
          if (kept_bytes !== exp_blk.kept) begin
            $error("kept_bytes expected %0d got %0d", exp_blk.kept, kept_bytes);
            fail_count++;
          end
          if (end_of_message !== exp_blk.eom) begin
            $error("end_of_message expected %b got %b", exp_blk.eom, end_of_message);
            fail_count++;
          end
          if (status !== exp_blk.bad) begin
            $error("status expected %b got %b", exp_blk.bad, status);
            fail_count++;
          end
        end
      end
    end
    pending = plain_q.size();
  end

endmodule

/* sim/tb_aes256_cbc_decrypt_pkcs7_top.sv */
// Testbench top for aes256_cbc_decrypt_pkcs7_top: clock, reset, register
// writes, message stimulus and verdict. Needs acd_pkg, the block and acd_checker.
`timescale 1ns / 1ps

module tb_aes256_cbc_decrypt_pkcs7_top import acd_pkg::*; ();

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_BLOCKS = 320;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] cipher_high = 64'h0;
  logic [63:0] cipher_low = 64'h0;
  logic        final_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  logic [4:0]  kept_bytes;
  logic        end_of_message;
  logic        status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = 6'h0;
  logic [63:0] pwdata = 64'h0;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          sent_blocks = 0;
  int          out_hold = 0;
  bit          idle_on = 1'b0;

  aes256_cbc_decrypt_pkcs7_top dut (.*);

  acd_checker chk (
    .clk, .rst, .in_valid, .in_stall, .cipher_high, .cipher_low, .final_block,
    .out_valid, .out_stall, .plain_high, .plain_low, .kept_bytes, .end_of_message,
    .status, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("aes256_cbc_decrypt_pkcs7_top: mismatch");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (!idle_on) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // receiver stall: a fresh wait drawn after each output transfer
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_valid && !out_stall) begin
      n = draw_wait();
      out_hold <= n;
      out_stall <= (n != 0);
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic reg_write(input int idx, input logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx * 8);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_block(input logic [127:0] c, input bit fin);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cipher_high <= c[127:64];
    cipher_low <= c[63:0];
    final_block <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_blocks++;
  endtask

  // drop valid and let every expected block come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // pad < 0 or len < 2: all random; else the last two blocks make the final
  // plaintext end in pad bytes (one if pad > 16 or 0); tamper corrupts one pad byte
  task automatic send_msg(input int len, input int pad, input bit tamper);
    logic [127:0] last_c;
    logic [127:0] want;
    int           span;
    int           pos;
    for (int i = 0; i < len - 2; i++) push_block(rand128(), 1'b0);
    if (len >= 2 && pad >= 0) begin
      last_c = rand128();
      want = rand128();
      span = (pad >= 1 && pad <= 16) ? pad : 1;
      for (int k = 16 - span; k < 16; k++) want[127-8*k -: 8] = 8'(pad);
      if (tamper && span >= 2) begin
        pos = $urandom_range(16 - span, 14);
        want[127-8*pos -: 8] ^= 8'($urandom_range(1, 255));
      end
      push_block(chk.inv_cipher(last_c) ^ want, 1'b0);
      push_block(last_c, 1'b1);
    end else begin
      if (len >= 2) push_block(rand128(), 1'b0);
      push_block(rand128(), 1'b1);
    end
  endtask

  task automatic load_regs(input logic [63:0] k0, k1, k2, k3, ivh, ivl);
    reg_write(REG_KEY0, k0);
    reg_write(REG_KEY1, k1);
    reg_write(REG_KEY2, k2);
    reg_write(REG_KEY3, k3);
    reg_write(REG_IV_HIGH, ivh);
    reg_write(REG_IV_LOW, ivl);
    // unmapped index, must be ignored
    reg_write($urandom_range(6, 7), {$urandom, $urandom});
  endtask

  initial begin
    int r;
    int base;
    logic [63:0] fill;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key and IV, extremes and padding corner cases
    push_block(128'h0, 1'b1);
    push_block({128{1'b1}}, 1'b1);
    push_block({128{1'b1}}, 1'b0);
    push_block(128'h0, 1'b1);
    send_msg(2, 1, 1'b0);
    send_msg(2, 16, 1'b0);
    send_msg(3, 0, 1'b0);
    send_msg(2, 17, 1'b0);
    send_msg(2, 255, 1'b0);
    send_msg(2, 8, 1'b1);
    send_msg(2, 16, 1'b1);
    send_msg(1, -1, 1'b0);
    push_block(rand128(), 1'b0);
    drain();

    // random phases; each starts from a new register setting, sometimes mid-message
    for (int ph = 0; ph < 6; ph++) begin
      fill = (ph == 2) ? 64'h0 : {64{1'b1}};
      if (ph == 0 || ph == 2)
        load_regs(fill, fill, fill, fill, fill, fill);
      else
        load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      base = sent_blocks;
      while (sent_blocks - base < PHASE_BLOCKS) begin
        idle_on = ($urandom_range(0, 4) != 0);
        r = $urandom_range(0, 9);
        if (r < 7) send_msg($urandom_range(1, 6), $urandom_range(1, 16), 1'b0);
        else if (r == 7) send_msg($urandom_range(2, 6), $urandom_range(2, 16), 1'b1);
        else if (r == 8)
          send_msg($urandom_range(2, 6), ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 255),
                   1'b0);
        else send_msg($urandom_range(1, 6), -1, 1'b0);
      end
      repeat ($urandom_range(0, 2)) push_block(rand128(), 1'b0);
      drain();
    end

    if (fail_count == 0) begin
      $display("aes256_cbc_decrypt_pkcs7_top: match");
    end else begin
      $display("aes256_cbc_decrypt_pkcs7_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/acd_pkg.sv
sv/aes256_cbc_decrypt_pkcs7_top.sv
sim/acd_checker.sv
sim/tb_aes256_cbc_decrypt_pkcs7_top.sv
